/* hdl/assert_macros.svh */
// assertion macros shared by the sequencer rtl
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/i2cseq_pkg.sv */
// package for the i2c master register transfer sequencer
// status codes, flag masks, completion codes and the request/result payload types
package i2cseq_pkg;

	// counter width default
	localparam int COUNT_WIDTH_DEFAULT = 16;

	// command codes
	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_STATUS = 1'b1;

	// controller status codes
	localparam logic [7:0] ST_BUS_ERROR  = 8'h00;
	localparam logic [7:0] ST_START_SENT = 8'h08;
	localparam logic [7:0] ST_RESTART    = 8'h10;
	localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
	localparam logic [7:0] ST_DATA_ACK   = 8'h28;
	localparam logic [7:0] ST_ARB_LOST   = 8'h38;
	localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
	localparam logic [7:0] ST_RDATA_ACK  = 8'h50;
	localparam logic [7:0] ST_RDATA_NACK = 8'h58;

	// address byte with the read bit cleared
	localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;

	// set flag masks
	localparam logic [2:0] SET_ACK   = 3'b001;
	localparam logic [2:0] SET_STOP  = 3'b010;
	localparam logic [2:0] SET_START = 3'b100;

	// clear flag masks
	localparam logic [2:0] CLR_ACK   = 3'b001;
	localparam logic [2:0] CLR_START = 3'b010;
	localparam logic [2:0] CLR_SI    = 3'b100;

	// completion codes
	localparam logic [1:0] DONE_BUSY  = 2'd0;
	localparam logic [1:0] DONE_READ  = 2'd1;
	localparam logic [1:0] DONE_WRITE = 2'd2;

	// one request
	typedef struct packed {
		logic        command;
		logic [7:0]  device_address;
		logic [7:0]  first_register;
		logic [15:0] transfer_length;
		logic [7:0]  status_code;
		logic [7:0]  received_byte;
		logic [7:0]  next_write_byte;
	} item_t;

	// one result
	typedef struct packed {
		logic        load_valid;
		logic [7:0]  load_byte;
		logic [2:0]  set_flags;
		logic [2:0]  clear_flags;
		logic        write_byte_taken;
		logic        read_valid;
		logic [7:0]  read_byte;
		logic [15:0] byte_index;
		logic [1:0]  completion;
		logic [7:0]  error_status;
	} result_t;

endpackage

/* hdl/i2cseq_if.sv */
// request and result channel interfaces of the sequencer
// valid/ready handshake; depends on nothing
interface i2cseq_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [7:0]  device_address;
	logic [7:0]  first_register;
	logic [15:0] transfer_length;
	logic [7:0]  status_code;
	logic [7:0]  received_byte;
	logic [7:0]  next_write_byte;

	modport source (
		output valid, command, device_address, first_register, transfer_length,
		output status_code, received_byte, next_write_byte,
		input  ready
	);
	modport sink (
		input  valid, command, device_address, first_register, transfer_length,
		input  status_code, received_byte, next_write_byte,
		output ready
	);
endinterface

interface i2cseq_rsp_if;
	logic        valid;
	logic        ready;
	logic        load_valid;
	logic [7:0]  load_byte;
	logic [2:0]  set_flags;
	logic [2:0]  clear_flags;
	logic        write_byte_taken;
	logic        read_valid;
	logic [7:0]  read_byte;
	logic [15:0] byte_index;
	logic [1:0]  completion;
	logic [7:0]  error_status;

	modport source (
		output valid, load_valid, load_byte, set_flags, clear_flags, write_byte_taken,
		output read_valid, read_byte, byte_index, completion, error_status,
		input  ready
	);
	modport sink (
		input  valid, load_valid, load_byte, set_flags, clear_flags, write_byte_taken,
		input  read_valid, read_byte, byte_index, completion, error_status,
		output ready
	);
endinterface

/* hdl/i2cseq_step.sv */
// per-event decode of the sequencer: result and next transfer state
// combinational; uses i2cseq_pkg types and codes
module i2cseq_step #(
	parameter int COUNT_WIDTH = i2cseq_pkg::COUNT_WIDTH_DEFAULT
) (
	input  i2cseq_pkg::item_t       item,
	input  logic [7:0]              addr,
	input  logic [7:0]              reg_idx,
	input  logic [COUNT_WIDTH-1:0]  remaining,
	input  logic [COUNT_WIDTH-1:0]  position,
	input  logic [7:0]              err,
	output i2cseq_pkg::result_t     res,
	output logic [7:0]              addr_d,
	output logic [7:0]              reg_idx_d,
	output logic [COUNT_WIDTH-1:0]  remaining_d,
	output logic [COUNT_WIDTH-1:0]  position_d,
	output logic [7:0]              err_d
);

	localparam logic [COUNT_WIDTH-1:0] CountOne  = COUNT_WIDTH'(1);
	localparam logic [COUNT_WIDTH-1:0] CountZero = '0;

	logic [31:0]            len_ext;
	logic [31:0]            pos_ext;
	logic [15:0]            index;
	logic [1:0]             finish;
	logic [COUNT_WIDTH-1:0] rem_sat_dec;
	logic [COUNT_WIDTH-1:0] pos_inc;

	// widened views so any counter width maps onto the 16-bit fields
	assign len_ext     = 32'(item.transfer_length);
	assign pos_ext     = 32'(position);
	assign index       = pos_ext[15:0];
	assign finish      = addr[0] ? i2cseq_pkg::DONE_READ : i2cseq_pkg::DONE_WRITE;
	assign pos_inc     = position + CountOne;
	assign rem_sat_dec = (remaining != CountZero) ? (remaining - CountOne) : remaining;

	// event decode
	always_comb begin
		res         = '0;
		addr_d      = addr;
		reg_idx_d   = reg_idx;
		remaining_d = remaining;
		position_d  = position;
		err_d       = err;
		if (item.command == i2cseq_pkg::CMD_START) begin
			addr_d        = item.device_address;
			reg_idx_d     = item.first_register;
			remaining_d   = len_ext[COUNT_WIDTH-1:0];
			position_d    = CountZero;
			err_d         = 8'h00;
			res.set_flags = i2cseq_pkg::SET_START;
		end else begin
			case (item.status_code)
				i2cseq_pkg::ST_START_SENT: begin
					res.load_valid  = 1'b1;
					res.load_byte   = addr & i2cseq_pkg::ADDR_WRITE_MASK;
					res.clear_flags = i2cseq_pkg::CLR_SI;
				end
				i2cseq_pkg::ST_RESTART: begin
					res.load_valid  = 1'b1;
					res.load_byte   = addr | 8'h01;
					res.clear_flags = i2cseq_pkg::CLR_SI;
				end
				i2cseq_pkg::ST_SLAW_ACK: begin
					if (remaining == CountZero) begin
						// probe only: stop right after the address ack
						res.clear_flags = i2cseq_pkg::CLR_START | i2cseq_pkg::CLR_SI;
						res.set_flags   = i2cseq_pkg::SET_STOP;
						res.completion  = finish;
					end else begin
						res.load_valid  = 1'b1;
						res.load_byte   = reg_idx;
						res.clear_flags = i2cseq_pkg::CLR_START | i2cseq_pkg::CLR_SI;
					end
				end
				i2cseq_pkg::ST_DATA_ACK: begin
					if (addr[0]) begin
						// register sent, repeated start for the read phase
						res.set_flags   = i2cseq_pkg::SET_START;
						res.clear_flags = i2cseq_pkg::CLR_SI;
					end else if (remaining == CountZero) begin
						res.clear_flags = i2cseq_pkg::CLR_START | i2cseq_pkg::CLR_SI;
						res.set_flags   = i2cseq_pkg::SET_STOP;
						res.completion  = finish;
					end else begin
						res.load_valid       = 1'b1;
						res.load_byte        = item.next_write_byte;
						res.write_byte_taken = 1'b1;
						res.byte_index       = index;
						res.clear_flags      = i2cseq_pkg::CLR_SI;
						position_d           = pos_inc;
						remaining_d          = remaining - CountOne;
					end
				end
				i2cseq_pkg::ST_SLAR_ACK: begin
					res.clear_flags = i2cseq_pkg::CLR_START | i2cseq_pkg::CLR_SI;
					if (remaining <= CountOne) begin
						res.clear_flags = res.clear_flags | i2cseq_pkg::CLR_ACK;
					end else begin
						res.set_flags = i2cseq_pkg::SET_ACK;
					end
				end
				i2cseq_pkg::ST_RDATA_ACK: begin
					res.read_valid  = 1'b1;
					res.read_byte   = item.received_byte;
					res.byte_index  = index;
					res.clear_flags = i2cseq_pkg::CLR_SI;
					position_d      = pos_inc;
					remaining_d     = rem_sat_dec;
					// nack the byte that will be the last one
					if (rem_sat_dec == CountOne) begin
						res.clear_flags = res.clear_flags | i2cseq_pkg::CLR_ACK;
					end else begin
						res.set_flags = i2cseq_pkg::SET_ACK;
					end
				end
				i2cseq_pkg::ST_RDATA_NACK: begin
					res.read_valid  = 1'b1;
					res.read_byte   = item.received_byte;
					res.byte_index  = index;
					res.clear_flags = i2cseq_pkg::CLR_START | i2cseq_pkg::CLR_SI;
					res.set_flags   = i2cseq_pkg::SET_STOP;
					res.completion  = finish;
				end
				i2cseq_pkg::ST_ARB_LOST: begin
					// bus is lost: no stop, no flag actions
					err_d          = item.status_code;
					res.completion = finish;
				end
				default: begin
					// bus error and unexpected codes end with stop
					err_d           = item.status_code;
					res.clear_flags = i2cseq_pkg::CLR_START | i2cseq_pkg::CLR_SI;
					res.set_flags   = i2cseq_pkg::SET_STOP;
					res.completion  = finish;
				end
			endcase
			res.error_status = err_d;
		end
	end

endmodule

/* hdl/i2c_master_register_transfer_sequencer.sv */
// i2c master register transfer sequencer: request register, then result register;
// throughput one request per cycle while rsp.ready keeps the result register draining,
// with a single decode pass between the two registers and the state update.
// a result waiting in the output register blocks the next accept once stage one is full.
// arst_n clears valid flags and transfer state (address, register, counts, error) to zero.
`include "assert_macros.svh"

module i2c_master_register_transfer_sequencer #(
	parameter int COUNT_WIDTH = i2cseq_pkg::COUNT_WIDTH_DEFAULT
) (
	input logic          clk,
	input logic          arst_n,
	i2cseq_req_if.sink   req,
	i2cseq_rsp_if.source rsp
);

	i2cseq_pkg::item_t      item_s1;
	logic                   valid_s1;
	i2cseq_pkg::result_t    res_q;
	logic                   rsp_valid_q;
	i2cseq_pkg::result_t    res_d;

	logic [7:0]             addr_q;
	logic [7:0]             reg_idx_q;
	logic [COUNT_WIDTH-1:0] remaining_q;
	logic [COUNT_WIDTH-1:0] position_q;
	logic [7:0]             err_q;
	logic [7:0]             addr_d;
	logic [7:0]             reg_idx_d;
	logic [COUNT_WIDTH-1:0] remaining_d;
	logic [COUNT_WIDTH-1:0] position_d;
	logic [7:0]             err_d;

	logic                   advance;
	logic                   req_fire;

	// stage one moves into the result register when that slot is free or draining
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign req_fire  = req.valid && req.ready;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_s1.command         <= req.command;
			item_s1.device_address  <= req.device_address;
			item_s1.first_register  <= req.first_register;
			item_s1.transfer_length <= req.transfer_length;
			item_s1.status_code     <= req.status_code;
			item_s1.received_byte   <= req.received_byte;
			item_s1.next_write_byte <= req.next_write_byte;
		end
	end

	// decode of the staged request against the transfer state
	i2cseq_step #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_step (
		.item        (item_s1),
		.addr        (addr_q),
		.reg_idx     (reg_idx_q),
		.remaining   (remaining_q),
		.position    (position_q),
		.err         (err_q),
		.res         (res_d),
		.addr_d      (addr_d),
		.reg_idx_d   (reg_idx_d),
		.remaining_d (remaining_d),
		.position_d  (position_d),
		.err_d       (err_d)
	);

	// transfer state, updated as each request leaves stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			reg_idx_q   <= '0;
			remaining_q <= '0;
			position_q  <= '0;
			err_q       <= '0;
		end else if (advance) begin
			addr_q      <= addr_d;
			reg_idx_q   <= reg_idx_d;
			remaining_q <= remaining_d;
			position_q  <= position_d;
			err_q       <= err_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	// result channel
	assign rsp.valid            = rsp_valid_q;
	assign rsp.load_valid       = res_q.load_valid;
	assign rsp.load_byte        = res_q.load_byte;
	assign rsp.set_flags        = res_q.set_flags;
	assign rsp.clear_flags      = res_q.clear_flags;
	assign rsp.write_byte_taken = res_q.write_byte_taken;
	assign rsp.read_valid       = res_q.read_valid;
	assign rsp.read_byte        = res_q.read_byte;
	assign rsp.byte_index       = res_q.byte_index;
	assign rsp.completion       = res_q.completion;
	assign rsp.error_status     = res_q.error_status;

	// checks
	`ASSERT_NEXT(a_s1_held, clk, arst_n, valid_s1 && !advance, valid_s1, "staged request lost")
	`ASSERT_IMPL(a_taken_loads, clk, arst_n, rsp_valid_q && res_q.write_byte_taken, res_q.load_valid, "write byte taken without load")
	`ASSERT_IMPL(a_rd_wr_excl, clk, arst_n, rsp_valid_q && res_q.read_valid, !res_q.write_byte_taken, "read and write in one result")
	`ASSERT_IMPL(a_done_code, clk, arst_n, rsp_valid_q, res_q.completion != 2'd3, "bad completion code")
	`ASSERT_NEXT(a_start_clears, clk, arst_n, advance && item_s1.command == i2cseq_pkg::CMD_START, err_q == 8'h00 && position_q == '0, "start did not clear state")

endmodule
